// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/lobm_pkg.sv =====
// Shared types and constants of the order book matcher.
package lobm_pkg;
  localparam int unsigned BookDepthDef = 32;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_DAYEND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_TRADE  = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2,
    ST_IGNORE = 2'd3
  } status_t;

  localparam logic [2:0] KIND_GTC = 3'd0;
  localparam logic [2:0] KIND_FAK = 3'd1;
  localparam logic [2:0] KIND_FOK = 3'd2;
  localparam logic [2:0] KIND_GFD = 3'd3;
  localparam logic [2:0] KIND_MKT = 3'd4;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic        side;
    logic [2:0]  kind;
    logic [31:0] price;
    logic [31:0] qty;
    logic        bad;   // zero quantity, or kind out of range on an add
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FIND,
    B_CHECK,
    B_SCAN,
    B_SCAN_END,
    B_INSERT,
    B_MATCH,
    B_MATCH_END,
    B_TRADE,
    B_PRUNE,
    B_FINISH
  } bstate_t;
endpackage

// ===== sv/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher.
// A command beat is taken when start is high and busy is low; a two-entry
// queue holds commands while the engine works, so busy rises only when it
// is full. Each command produces zero or more trade beats followed by one
// status beat with out_last set; every beat is on the out_ ports for one
// cycle with out_strobe high and cannot be held off. Work per command is set
// by the engine's slot sweeps, one slot per cycle: a key search, a book scan
// for adds and modifies, and a best bid and ask sweep for every trade and the
// final check. Day end sweeps the book once more to drop day orders.
module limit_order_book_matcher #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::BookDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_order_key,
  input  logic        in_side,
  input  logic [2:0]  in_order_kind,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_quantity,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_buyer_key,
  output logic [31:0] out_buyer_price,
  output logic [31:0] out_seller_key,
  output logic [31:0] out_seller_price,
  output logic [31:0] out_traded_quantity,
  output logic [5:0]  out_resting_count,
  output logic        out_last
);
`include "assert_macros.svh"

  logic           q_valid, q_pop;
  lobm_pkg::cmd_t q_cmd;

  lobm_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_order_key, .in_side, .in_order_kind,
    .in_limit_price, .in_quantity,
    .q_valid, .q_cmd, .q_pop
  );

  lobm_engine #(.BOOK_DEPTH(BOOK_DEPTH)) u_engine (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .out_strobe, .out_status, .out_buyer_key, .out_buyer_price,
    .out_seller_key, .out_seller_price, .out_traded_quantity,
    .out_resting_count, .out_last
  );

  // a trade beat never closes a command
  `ASSERT_IMPL(a_trade_not_last, clk, rst_n,
    out_strobe && out_status == lobm_pkg::ST_TRADE, !out_last)
  // a final beat is never directly followed by another beat
  `ASSERT_NEXT(a_last_gap, clk, rst_n, out_strobe && out_last, !out_strobe)
  // the engine only pops a queue that holds a command
  `ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid)
endmodule

// ===== sv/lobm_front.sv =====
// Command intake, classification and a small queue toward the engine.
module lobm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_order_key,
  input  logic                in_side,
  input  logic [2:0]          in_order_kind,
  input  logic [31:0]         in_limit_price,
  input  logic [31:0]         in_quantity,
  output logic                q_valid,
  output lobm_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);
  localparam int unsigned AW = $clog2(lobm_pkg::QDepth);
  localparam logic [AW:0] QFull = (AW+1)'(lobm_pkg::QDepth);

  lobm_pkg::cmd_t    mem_r [lobm_pkg::QDepth];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              push;
  lobm_pkg::cmd_t    cmd;

  assign busy = (cnt_r == QFull);
  assign push = start && !busy;

  // modify keeps the stored kind, so only an add checks the kind code
  always_comb begin
    cmd.op    = lobm_pkg::op_t'(in_operation);
    cmd.key   = in_order_key;
    cmd.side  = in_side;
    cmd.kind  = in_order_kind;
    cmd.price = in_limit_price;
    cmd.qty   = in_quantity;
    cmd.bad   = (in_quantity == 32'd0) ||
                ((lobm_pkg::op_t'(in_operation) == lobm_pkg::OP_ADD) &&
                 (in_order_kind > lobm_pkg::KIND_MKT));
  end

  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
  end
endmodule

// ===== sv/lobm_engine.sv =====
// Book storage and sequential matching engine.
module lobm_engine #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::BookDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lobm_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [31:0]        out_buyer_key,
  output logic [31:0]        out_buyer_price,
  output logic [31:0]        out_seller_key,
  output logic [31:0]        out_seller_price,
  output logic [31:0]        out_traded_quantity,
  output logic [5:0]         out_resting_count,
  output logic               out_last
);
  localparam int unsigned IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned AVW = 32 + CW;  // sum of every resting quantity

  // per-slot registers, swept one slot at a time through idx_r
  logic [BOOK_DEPTH-1:0] vld_r, vld_nxt;
  logic [31:0] key_r   [BOOK_DEPTH];
  logic        side_r  [BOOK_DEPTH];
  logic [1:0]  kind_r  [BOOK_DEPTH];
  logic [31:0] price_r [BOOK_DEPTH];
  logic [31:0] rem_r   [BOOK_DEPTH];
  logic [31:0] stamp_r [BOOK_DEPTH];
  logic [31:0] stampc_r;

  lobm_pkg::bstate_t st_r, st_nxt;
  lobm_pkg::cmd_t    c_r;
  logic [2:0]        kind_eff_r;
  logic [IW-1:0]     idx_r, slot_r, bi_r, ai_r, wi_r, hit_r;
  logic              idx_last;
  logic              bf_r, af_r, wf_r, hitf_r;
  logic [AVW-1:0]    avail_r;
  logic [CW-1:0]     cnt_r;
  logic [1:0]        res_st_r;

  // output registers
  logic        ostb_r;
  logic [1:0]  ost_r;
  logic [31:0] obk_r, obp_r, osk_r, osp_r, oq_r;
  logic        olast_r;

  logic        opp;
  logic [31:0] ip, ia;
  logic        cur_v;

  assign idx_last = (idx_r == IW'(BOOK_DEPTH - 1));
  assign opp = ~c_r.side;
  assign cur_v = vld_r[idx_r];

  function automatic logic better(input logic sd, input logic [31:0] pn,
                                  input logic [31:0] pb, input logic [31:0] agen,
                                  input logic [31:0] ageb);
    if (pn == pb) better = agen > ageb;
    else better = sd ? (pn < pb) : (pn > pb);
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lobm_pkg::B_IDLE:   if (q_valid) st_nxt = lobm_pkg::B_FIND;
      lobm_pkg::B_FIND:   if (idx_last) st_nxt = lobm_pkg::B_CHECK;
      lobm_pkg::B_CHECK: begin
        st_nxt = lobm_pkg::B_FINISH;
        if (c_r.op == lobm_pkg::OP_DAYEND) st_nxt = lobm_pkg::B_PRUNE;
        else if (c_r.op == lobm_pkg::OP_ADD && !hitf_r && !c_r.bad)
          st_nxt = lobm_pkg::B_SCAN;
        else if (c_r.op == lobm_pkg::OP_MODIFY && hitf_r && !c_r.bad)
          st_nxt = lobm_pkg::B_SCAN;
      end
      lobm_pkg::B_SCAN:     if (idx_last) st_nxt = lobm_pkg::B_SCAN_END;
      lobm_pkg::B_SCAN_END: st_nxt = lobm_pkg::B_INSERT;
      lobm_pkg::B_INSERT:   st_nxt = (res_st_r == lobm_pkg::ST_REJECT || !bf_r) ?
                                     lobm_pkg::B_FINISH : lobm_pkg::B_MATCH;
      lobm_pkg::B_MATCH:    if (idx_last) st_nxt = lobm_pkg::B_MATCH_END;
      lobm_pkg::B_MATCH_END:
        st_nxt = (bf_r && af_r && price_r[bi_r] >= price_r[ai_r]) ?
                 lobm_pkg::B_TRADE : lobm_pkg::B_FINISH;
      lobm_pkg::B_TRADE:    st_nxt = lobm_pkg::B_MATCH;
      lobm_pkg::B_PRUNE:    if (idx_last) st_nxt = lobm_pkg::B_FINISH;
      lobm_pkg::B_FINISH:   st_nxt = lobm_pkg::B_IDLE;
      default:              st_nxt = lobm_pkg::B_IDLE;
    endcase
  end

  assign q_pop = (st_r == lobm_pkg::B_IDLE) && q_valid;

  // datapath
  logic [31:0] tq;
  always_comb begin
    vld_nxt = vld_r;
    tq = (rem_r[bi_r] < rem_r[ai_r]) ? rem_r[bi_r] : rem_r[ai_r];
    ip = price_r[idx_r];
    ia = stampc_r - stamp_r[idx_r];
    case (st_r)
      lobm_pkg::B_CHECK:
        if ((c_r.op == lobm_pkg::OP_CANCEL || c_r.op == lobm_pkg::OP_MODIFY) && hitf_r)
          vld_nxt[hit_r] = 1'b0;
      lobm_pkg::B_INSERT:
        if (res_st_r != lobm_pkg::ST_REJECT && bf_r) vld_nxt[slot_r] = 1'b1;
      lobm_pkg::B_TRADE: begin
        if (rem_r[bi_r] == tq) vld_nxt[bi_r] = 1'b0;
        if (rem_r[ai_r] == tq) vld_nxt[ai_r] = 1'b0;
      end
      lobm_pkg::B_PRUNE:
        if (cur_v && kind_r[idx_r] == lobm_pkg::KIND_GFD[1:0]) vld_nxt[idx_r] = 1'b0;
      lobm_pkg::B_FINISH:
        if (res_st_r == lobm_pkg::ST_DONE && hitf_r == 1'b1 && kind_eff_r == lobm_pkg::KIND_FAK
            && (c_r.op == lobm_pkg::OP_ADD || c_r.op == lobm_pkg::OP_MODIFY) && vld_r[slot_r])
          vld_nxt[slot_r] = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= lobm_pkg::B_IDLE;
      vld_r    <= '0;
      stampc_r <= '0;
      cnt_r    <= '0;
      ostb_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      vld_r  <= vld_nxt;
      ostb_r <= (st_r == lobm_pkg::B_TRADE) || (st_r == lobm_pkg::B_FINISH);
      cnt_r  <= CW'($countones(vld_nxt));
      if (st_r == lobm_pkg::B_INSERT && res_st_r != lobm_pkg::ST_REJECT && bf_r)
        stampc_r <= stampc_r + 32'd1;
    end
  end

  // working registers; bf_r doubles as "free slot found" in the scan phase
  always_ff @(posedge clk) begin
    case (st_r)
      lobm_pkg::B_IDLE: begin
        c_r    <= q_cmd;
        idx_r  <= '0;
        hitf_r <= 1'b0;
        hit_r  <= '0;
      end
      lobm_pkg::B_FIND: begin
        if (cur_v && key_r[idx_r] == c_r.key) begin
          hitf_r <= 1'b1;
          hit_r  <= idx_r;
        end
        idx_r <= idx_r + 1'b1;
      end
      lobm_pkg::B_CHECK: begin
        idx_r      <= '0;
        kind_eff_r <= (c_r.op == lobm_pkg::OP_MODIFY) ? {1'b0, kind_r[hit_r]} : c_r.kind;
        if (c_r.op == lobm_pkg::OP_ADD && hitf_r) res_st_r <= lobm_pkg::ST_IGNORE;
        else if ((c_r.op == lobm_pkg::OP_CANCEL || c_r.op == lobm_pkg::OP_MODIFY) && !hitf_r)
          res_st_r <= lobm_pkg::ST_IGNORE;
        else if ((c_r.op == lobm_pkg::OP_ADD || c_r.op == lobm_pkg::OP_MODIFY) && c_r.bad)
          res_st_r <= lobm_pkg::ST_REJECT;
        else
          res_st_r <= lobm_pkg::ST_DONE;
        bf_r <= 1'b0; af_r <= 1'b0; wf_r <= 1'b0; avail_r <= '0;
      end
      lobm_pkg::B_SCAN: begin
        idx_r <= idx_r + 1'b1;
        if (!cur_v && !bf_r) begin
          bf_r <= 1'b1; slot_r <= idx_r;
        end
        if (cur_v && side_r[idx_r] == opp) begin
          if (!af_r || better(opp, ip, price_r[ai_r], ia,
                              stampc_r - stamp_r[ai_r])) begin
            af_r <= 1'b1; ai_r <= idx_r;
          end
          if (!wf_r || (opp ? ip > price_r[wi_r] : ip < price_r[wi_r])) begin
            wf_r <= 1'b1; wi_r <= idx_r;
          end
          if (c_r.side ? ip >= c_r.price : ip <= c_r.price)
            avail_r <= avail_r + {{CW{1'b0}}, rem_r[idx_r]};
        end
      end
      lobm_pkg::B_SCAN_END: begin
        if (kind_eff_r == lobm_pkg::KIND_MKT) begin
          if (!wf_r) res_st_r <= lobm_pkg::ST_REJECT;
          c_r.price  <= price_r[wi_r];
          kind_eff_r <= lobm_pkg::KIND_GTC;
        end else if (kind_eff_r == lobm_pkg::KIND_FAK) begin
          if (!af_r || (c_r.side ? c_r.price > price_r[ai_r] : c_r.price < price_r[ai_r]))
            res_st_r <= lobm_pkg::ST_REJECT;
        end else if (kind_eff_r == lobm_pkg::KIND_FOK) begin
          if (avail_r < {{CW{1'b0}}, c_r.qty}) res_st_r <= lobm_pkg::ST_REJECT;
        end
      end
      lobm_pkg::B_INSERT: begin
        if (!bf_r) res_st_r <= lobm_pkg::ST_REJECT;
        hitf_r <= 1'b1;  // marks that the insert step ran, placed or not
        idx_r <= '0; bf_r <= 1'b0; af_r <= 1'b0;
      end
      lobm_pkg::B_MATCH: begin
        idx_r <= idx_r + 1'b1;
        if (cur_v && !side_r[idx_r] && (!bf_r || better(1'b0, ip, price_r[bi_r], ia,
            stampc_r - stamp_r[bi_r]))) begin
          bf_r <= 1'b1; bi_r <= idx_r;
        end
        if (cur_v && side_r[idx_r] && (!af_r || better(1'b1, ip, price_r[ai_r], ia,
            stampc_r - stamp_r[ai_r]))) begin
          af_r <= 1'b1; ai_r <= idx_r;
        end
      end
      lobm_pkg::B_TRADE: begin
        idx_r <= '0; bf_r <= 1'b0; af_r <= 1'b0;
      end
      lobm_pkg::B_PRUNE: idx_r <= idx_r + 1'b1;
      default: ;
    endcase
    if (st_r == lobm_pkg::B_INSERT && res_st_r != lobm_pkg::ST_REJECT && bf_r) begin
      key_r[slot_r]   <= c_r.key;
      side_r[slot_r]  <= c_r.side;
      kind_r[slot_r]  <= kind_eff_r[1:0];
      price_r[slot_r] <= c_r.price;
      rem_r[slot_r]   <= c_r.qty;
      stamp_r[slot_r] <= stampc_r;
    end
    if (st_r == lobm_pkg::B_TRADE) begin
      rem_r[bi_r] <= rem_r[bi_r] - tq;
      rem_r[ai_r] <= rem_r[ai_r] - tq;
    end
    if (st_r == lobm_pkg::B_TRADE) begin
      ost_r <= lobm_pkg::ST_TRADE; olast_r <= 1'b0;
      obk_r <= key_r[bi_r]; obp_r <= price_r[bi_r];
      osk_r <= key_r[ai_r]; osp_r <= price_r[ai_r]; oq_r <= tq;
    end else if (st_r == lobm_pkg::B_FINISH) begin
      ost_r <= res_st_r; olast_r <= 1'b1;
      obk_r <= '0; obp_r <= '0; osk_r <= '0; osp_r <= '0; oq_r <= '0;
    end else begin
      ost_r <= lobm_pkg::ST_TRADE; olast_r <= 1'b0;
      obk_r <= '0; obp_r <= '0; osk_r <= '0; osp_r <= '0; oq_r <= '0;
    end
  end

  assign out_strobe          = ostb_r;
  assign out_status          = ost_r;
  assign out_buyer_key       = obk_r;
  assign out_buyer_price     = obp_r;
  assign out_seller_key      = osk_r;
  assign out_seller_price    = osp_r;
  assign out_traded_quantity = oq_r;
  assign out_resting_count   = 6'(cnt_r);
  assign out_last            = olast_r;
endmodule

// ===== verif/limit_order_book_matcher_checker.sv =====
// Book predictor and result scoreboard for the order book matcher.
module limit_order_book_matcher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_order_key,
  input  logic        in_side,
  input  logic [2:0]  in_order_kind,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_quantity,
  input  logic        out_strobe,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_buyer_key,
  input  logic [31:0] out_buyer_price,
  input  logic [31:0] out_seller_key,
  input  logic [31:0] out_seller_price,
  input  logic [31:0] out_traded_quantity,
  input  logic [5:0]  out_resting_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = lobm_pkg::BookDepthDef;
  localparam logic SideBuy = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef struct {
    lobm_pkg::status_t status;
    logic [31:0] buyer_key;
    logic [31:0] buyer_price;
    logic [31:0] seller_key;
    logic [31:0] seller_price;
    logic [31:0] qty;
    logic [5:0]  resting;
    logic        last;
  } fill_beat_t;

  fill_beat_t  expected_beats[$];

  logic        live[Depth];
  logic [31:0] o_key[Depth];
  logic        o_side[Depth];
  logic [1:0]  o_kind[Depth];
  logic [31:0] o_price[Depth];
  logic [31:0] o_left[Depth];
  logic [31:0] o_stamp[Depth];
  logic [31:0] stamp_now;

  initial begin
    fail_count = 0;
    stamp_now = '0;
    for (int i = 0; i < Depth; i++) live[i] = 1'b0;
  end

  assign pending_beats = expected_beats.size();

  function automatic int slot_of(logic [31:0] key);
    for (int i = 0; i < Depth; i++)
      if (live[i] && o_key[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [5:0] live_count();
    int c = 0;
    for (int i = 0; i < Depth; i++) c += live[i];
    return c[5:0];
  endfunction

  // Highest bid / lowest ask; ties go to the larger age.
  function automatic int best_on(logic sd);
    int b = -1;
    for (int i = 0; i < Depth; i++) begin
      if (!live[i] || o_side[i] != sd) continue;
      if (b < 0) begin
        b = i;
      end else if (o_price[i] == o_price[b]) begin
        if ((stamp_now - o_stamp[i]) > (stamp_now - o_stamp[b])) b = i;
      end else if (sd == SideBuy ? o_price[i] > o_price[b] : o_price[i] < o_price[b]) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic int worst_on(logic sd);
    int w = -1;
    for (int i = 0; i < Depth; i++) begin
      if (!live[i] || o_side[i] != sd) continue;
      if (w < 0 || (sd == SideBuy ? o_price[i] < o_price[w] : o_price[i] > o_price[w]))
        w = i;
    end
    return w;
  endfunction

  function automatic void post(lobm_pkg::status_t st, logic [31:0] bk, logic [31:0] bp,
                               logic [31:0] sk, logic [31:0] sp, logic [31:0] q,
                               logic lst);
    fill_beat_t b;
    b.status = st; b.buyer_key = bk; b.buyer_price = bp;
    b.seller_key = sk; b.seller_price = sp; b.qty = q;
    b.resting = live_count(); b.last = lst;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic lobm_pkg::status_t place_order(logic [31:0] key, logic sd,
                                                    logic [2:0] kind, logic [31:0] price,
                                                    logic [31:0] qty);
    logic        opp = ~sd;
    int          o;
    int          slot = -1;
    logic [63:0] avail = '0;
    logic [31:0] q;
    int          b, a;
    if (slot_of(key) >= 0) return lobm_pkg::ST_IGNORE;
    if (kind > lobm_pkg::KIND_MKT || qty == 0) return lobm_pkg::ST_REJECT;
    if (kind == lobm_pkg::KIND_MKT) begin
      o = worst_on(opp);
      if (o < 0) return lobm_pkg::ST_REJECT;
      price = o_price[o];
      kind = lobm_pkg::KIND_GTC;
    end
    if (kind == lobm_pkg::KIND_FAK) begin
      o = best_on(opp);
      if (o < 0 || (sd == SideBuy ? price < o_price[o] : price > o_price[o]))
        return lobm_pkg::ST_REJECT;
    end
    if (kind == lobm_pkg::KIND_FOK) begin
      for (int i = 0; i < Depth; i++)
        if (live[i] && o_side[i] == opp &&
            (sd == SideBuy ? o_price[i] <= price : o_price[i] >= price))
          avail += o_left[i];
      if (avail < {32'd0, qty}) return lobm_pkg::ST_REJECT;
    end
    for (int i = 0; i < Depth; i++)
      if (!live[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) return lobm_pkg::ST_REJECT;
    live[slot] = 1'b1; o_key[slot] = key; o_side[slot] = sd;
    o_kind[slot] = kind[1:0]; o_price[slot] = price; o_left[slot] = qty;
    o_stamp[slot] = stamp_now;
    stamp_now++;
    forever begin
      b = best_on(SideBuy);
      a = best_on(SideSell);
      if (b < 0 || a < 0 || o_price[b] < o_price[a]) break;
      q = o_left[b] < o_left[a] ? o_left[b] : o_left[a];
      o_left[b] -= q;
      o_left[a] -= q;
      if (o_left[b] == 0) live[b] = 1'b0;
      if (o_left[a] == 0) live[a] = 1'b0;
      post(lobm_pkg::ST_TRADE, o_key[b], o_price[b], o_key[a], o_price[a], q, 1'b0);
    end
    // an unfilled fill-and-kill remainder never rests
    if (live[slot] && o_kind[slot] == lobm_pkg::KIND_FAK[1:0]) live[slot] = 1'b0;
    return lobm_pkg::ST_DONE;
  endfunction

  function automatic void apply_command();
    lobm_pkg::status_t st = lobm_pkg::ST_DONE;
    int      i;
    logic [2:0] old_kind;
    case (lobm_pkg::op_t'(in_operation))
      lobm_pkg::OP_ADD: begin
        st = place_order(in_order_key, in_side, in_order_kind, in_limit_price, in_quantity);
      end
      lobm_pkg::OP_CANCEL: begin
        i = slot_of(in_order_key);
        if (i < 0) st = lobm_pkg::ST_IGNORE;
        else live[i] = 1'b0;
      end
      lobm_pkg::OP_MODIFY: begin
        i = slot_of(in_order_key);
        if (i < 0) begin
          st = lobm_pkg::ST_IGNORE;
        end else begin
          old_kind = {1'b0, o_kind[i]};
          live[i] = 1'b0;
          st = place_order(in_order_key, in_side, old_kind, in_limit_price, in_quantity);
        end
      end
      default: begin
        for (int j = 0; j < Depth; j++)
          if (live[j] && o_kind[j] == lobm_pkg::KIND_GFD[1:0]) live[j] = 1'b0;
      end
    endcase
    post(st, '0, '0, '0, '0, '0, 1'b1);
  endfunction

  function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    fill_beat_t e;
    if (rst_n) begin
      if (start && !busy) apply_command();
      if (out_strobe) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual status %0d key %0h/%0h",
                   $time, out_status, out_buyer_key, out_seller_key);
          fail_count++;
        end else begin
          e = expected_beats[0];
          expected_beats.delete(0);
          field_check("status", e.status, out_status);
          field_check("buyer_key", e.buyer_key, out_buyer_key);
          field_check("buyer_price", e.buyer_price, out_buyer_price);
          field_check("seller_key", e.seller_key, out_seller_key);
          field_check("seller_price", e.seller_price, out_seller_price);
          field_check("traded_quantity", e.qty, out_traded_quantity);
          field_check("resting_count", e.resting, out_resting_count);
          field_check("last", e.last, out_last);
        end
      end
    end
  end
endmodule

// ===== verif/limit_order_book_matcher_test.sv =====
// Stimulus, clock, reset and verdict for the order book matcher.
module limit_order_book_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;  // cycles without any accepted beat
  localparam int TailCycles = 300;    // engine settling after the last status

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = lobm_pkg::OP_ADD;
  logic [31:0] in_order_key = '0;
  logic        in_side = 1'b0;
  logic [2:0]  in_order_kind = lobm_pkg::KIND_GTC;
  logic [31:0] in_limit_price = '0;
  logic [31:0] in_quantity = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [31:0] out_buyer_key, out_buyer_price, out_seller_key, out_seller_price;
  logic [31:0] out_traded_quantity;
  logic [5:0]  out_resting_count;
  logic        out_last;
  int          fail_count, pending_beats;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  limit_order_book_matcher dut (.*);

  limit_order_book_matcher_checker scoreboard (.*);

  // Watchdog: any accepted command or result beat restarts the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("limit_order_book_matcher verification failed");
      $finish;
    end
  end

  // Presents one command beat and returns at the edge that takes it. Leaves
  // start high so a following beat can go out back to back.
  task automatic send(lobm_pkg::op_t op, logic [31:0] key, logic sd, logic [2:0] kind,
                      logic [31:0] price, logic [31:0] qty);
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_order_key <= key;
    in_side <= sd;
    in_order_kind <= kind;
    in_limit_price <= price;
    in_quantity <= qty;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds the sender off until every predicted beat has been seen.
  task automatic drain_book_traffic();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  // One random command. In rest mode prices stay apart so the book fills.
  task automatic random_command(bit rest_mode);
    lobm_pkg::op_t op;
    logic [31:0] key, price, qty;
    logic [2:0]  kind;
    logic        sd;
    int          r;
    r = $urandom_range(99, 0);
    op = r < 60 ? lobm_pkg::OP_ADD : r < 76 ? lobm_pkg::OP_CANCEL :
         r < 94 ? lobm_pkg::OP_MODIFY : lobm_pkg::OP_DAYEND;
    key = $urandom_range(99, 0) < 85 ? 32'($urandom_range(40, 1)) : $urandom;
    sd = 1'($urandom_range(1, 0));
    r = $urandom_range(99, 0);
    if (r < 3) price = '0;
    else if (r < 6) price = '1;
    else if (r < 10) price = $urandom;
    else if (rest_mode) price = sd ? 32'($urandom_range(150, 110)) : 32'($urandom_range(90, 50));
    else price = 32'($urandom_range(106, 94));
    r = $urandom_range(99, 0);
    qty = r < 4 ? 32'd0 : r < 12 ? $urandom : 32'($urandom_range(30, 1));
    r = $urandom_range(99, 0);
    kind = r < 5 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    if (rest_mode && r < 70) kind = $urandom_range(1, 0) ? lobm_pkg::KIND_GTC : lobm_pkg::KIND_GFD;
    send(op, key, sd, kind, price, qty);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-book rejects, bad kind, zero quantity.
    send(lobm_pkg::OP_ADD, 32'd50, 1'b0, lobm_pkg::KIND_MKT, 32'd100, 32'd5);
    send(lobm_pkg::OP_ADD, 32'd51, 1'b1, lobm_pkg::KIND_FAK, 32'd100, 32'd5);
    send(lobm_pkg::OP_ADD, 32'd52, 1'b0, lobm_pkg::KIND_FOK, 32'd100, 32'd5);
    send(lobm_pkg::OP_ADD, 32'd53, 1'b0, 3'd7, 32'd100, 32'd5);
    send(lobm_pkg::OP_ADD, 32'd54, 1'b0, lobm_pkg::KIND_GTC, 32'd100, 32'd0);
    // Resting orders, duplicate key, market reprice at the worst bid.
    send(lobm_pkg::OP_ADD, 32'd1, 1'b0, lobm_pkg::KIND_GTC, 32'd100, 32'd10);
    send(lobm_pkg::OP_ADD, 32'd1, 1'b0, lobm_pkg::KIND_GTC, 32'd101, 32'd10);
    send(lobm_pkg::OP_ADD, 32'd2, 1'b1, lobm_pkg::KIND_GTC, 32'd105, 32'd5);
    send(lobm_pkg::OP_ADD, 32'd3, 1'b0, lobm_pkg::KIND_GFD, 32'd99, 32'd8);
    send(lobm_pkg::OP_ADD, 32'd9, 1'b0, lobm_pkg::KIND_GTC, 32'd100, 32'd3);
    send(lobm_pkg::OP_ADD, 32'd4, 1'b1, lobm_pkg::KIND_MKT, 32'd0, 32'd12);
    // Fill and kill with leftover; fill or kill short and covered.
    send(lobm_pkg::OP_ADD, 32'd5, 1'b1, lobm_pkg::KIND_FAK, 32'd99, 32'd20);
    send(lobm_pkg::OP_ADD, 32'd6, 1'b0, lobm_pkg::KIND_FOK, 32'd105, 32'd100);
    send(lobm_pkg::OP_ADD, 32'd7, 1'b0, lobm_pkg::KIND_FOK, 32'd105, 32'd5);
    // Cancel and modify, known and unknown; day end.
    send(lobm_pkg::OP_ADD, 32'd8, 1'b0, lobm_pkg::KIND_GFD, 32'd90, 32'd4);
    send(lobm_pkg::OP_ADD, 32'd10, 1'b1, lobm_pkg::KIND_GTC, 32'd120, 32'd4);
    send(lobm_pkg::OP_CANCEL, 32'd77, 1'b0, lobm_pkg::KIND_GTC, 32'd0, 32'd0);
    send(lobm_pkg::OP_MODIFY, 32'd78, 1'b0, lobm_pkg::KIND_GTC, 32'd1, 32'd1);
    send(lobm_pkg::OP_MODIFY, 32'd10, 1'b1, lobm_pkg::KIND_MKT, 32'd95, 32'd2);
    send(lobm_pkg::OP_MODIFY, 32'd8, 1'b0, lobm_pkg::KIND_GTC, 32'd91, 32'd0);
    send(lobm_pkg::OP_CANCEL, 32'd10, 1'b0, lobm_pkg::KIND_GTC, 32'd0, 32'd0);
    send(lobm_pkg::OP_DAYEND, 32'hFFFF_FFFF, 1'b1, 3'd7, '1, '1);
    // Field extremes crossing into one full-size trade.
    send(lobm_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0, lobm_pkg::KIND_GTC, 32'hFFFF_FFFF,
         32'hFFFF_FFFF);
    send(lobm_pkg::OP_ADD, 32'd0, 1'b1, lobm_pkg::KIND_GTC, 32'd0, 32'hFFFF_FFFF);
    drain_book_traffic();

    // Random phases: back to back, sparse sender, book filling, moderate.
    idle_pct = 0;
    repeat (46) random_command(1'b0);
    drain_book_traffic();
    idle_pct = 78;
    repeat (46) random_command(1'b0);
    drain_book_traffic();
    idle_pct = 0;
    repeat (46) random_command(1'b1);
    drain_book_traffic();
    idle_pct = 32;
    repeat (48) random_command(1'b0);

    drain_book_traffic();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0)
      $display("limit_order_book_matcher verification clean");
    else
      $display("limit_order_book_matcher verification failed");
    $finish;
  end
endmodule

// ===== limit_order_book_matcher.f =====
+incdir+sv
sv/lobm_pkg.sv
sv/lobm_front.sv
sv/lobm_engine.sv
sv/limit_order_book_matcher.sv
verif/limit_order_book_matcher_checker.sv
verif/limit_order_book_matcher_test.sv
